// ===== hdl/i2cms_pkg.sv =====
// Shared types and constants of the I2C master bit sequencer.
// Used by the front, queue, back and top modules; depends on nothing.
package i2cms_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_t;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [4:0] WRITE_LEN     = 5'd27;
  localparam logic [4:0] READ_LEN      = 5'd20;
  localparam logic [4:0] SHORT_LEN     = 5'd3;
  localparam logic [4:0] READ_BIT_END  = 5'd16;
  localparam logic [4:0] READ_ACK_SDA  = 5'd17;
  localparam logic [4:0] READ_ACK_SCL  = 5'd18;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_data;
    logic       ack_to_send;
    logic       sda_line;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/i2cms_front.sv =====
// Front part: accepts input items and classifies the action code.
// Depends on i2cms_pkg; feeds i2cms_queue.
module i2cms_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic [7:0]         write_data,
  input  logic               ack_to_send,
  input  logic               sda_line,
  input  i2cms_pkg::q_stat_t q_stat,
  output logic               push,
  output i2cms_pkg::item_t   push_item
);

  i2cms_pkg::cmd_t cmd;

  always_comb begin
    unique case (action)
      3'd1:    cmd = i2cms_pkg::CMD_START;
      3'd2:    cmd = i2cms_pkg::CMD_WRITE;
      3'd3:    cmd = i2cms_pkg::CMD_READ;
      3'd4:    cmd = i2cms_pkg::CMD_STOP;
      default: cmd = i2cms_pkg::CMD_IDLE;
    endcase
  end

  assign in_stall               = q_stat.full;
  assign push                   = in_valid && !q_stat.full;
  assign push_item.cmd          = cmd;
  assign push_item.write_data   = write_data;
  assign push_item.ack_to_send  = ack_to_send;
  assign push_item.sda_line     = sda_line;

endmodule

// ===== hdl/i2cms_queue.sv =====
// Two-entry item queue between front and back.
// Depends on i2cms_pkg.
module i2cms_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  i2cms_pkg::item_t   push_item,
  input  logic               pop,
  output i2cms_pkg::item_t   head,
  output i2cms_pkg::q_stat_t q_stat
);

  i2cms_pkg::item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);

endmodule

// ===== hdl/i2cms_back.sv =====
// Back part: plays one bus tick per item and holds the result register.
// Depends on i2cms_pkg; pops items from i2cms_queue.
module i2cms_back (
  input  logic               clk,
  input  logic               rst,
  input  i2cms_pkg::item_t   head,
  input  i2cms_pkg::q_stat_t q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               scl_level,
  output logic               sda_level,
  output logic               busy_res,
  output logic               done_res,
  output logic [7:0]         read_byte,
  output logic               slave_ack
);

  i2cms_pkg::cmd_t cur_cmd, cur_cmd_next;
  logic [4:0] phase, phase_next;
  logic [1:0] tri_cnt, tri_cnt_next;
  logic [3:0] bit_cnt, bit_cnt_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic       held_ack, held_ack_next;
  logic       scl_reg, scl_next;
  logic       sda_reg, sda_next;
  logic       ack_seen, ack_seen_next;
  logic       sample_pending, sample_pending_next;
  logic [7:0] read_result, read_result_next;
  logic       busy, done;

  i2cms_pkg::cmd_t cmd_c;
  logic [4:0] len;

  assign pop = !q_stat.empty && (!out_valid || !out_stall);

  always_comb begin
    shift_byte_next     = shift_byte;
    ack_seen_next       = ack_seen;
    held_ack_next       = held_ack;
    cmd_c               = cur_cmd;
    phase_next          = phase;
    tri_cnt_next        = tri_cnt;
    bit_cnt_next        = bit_cnt;
    scl_next            = scl_reg;
    sda_next            = sda_reg;
    sample_pending_next = 1'b0;
    read_result_next    = read_result;
    cur_cmd_next        = cur_cmd;
    busy                = 1'b0;
    done                = 1'b0;
    len                 = i2cms_pkg::SHORT_LEN;

    if (sample_pending) begin
      if (cur_cmd == i2cms_pkg::CMD_WRITE) ack_seen_next = head.sda_line;
      else if (cur_cmd == i2cms_pkg::CMD_READ)
        shift_byte_next = {shift_byte[6:0], head.sda_line};
    end

    if (cur_cmd == i2cms_pkg::CMD_IDLE && head.cmd != i2cms_pkg::CMD_IDLE) begin
      cmd_c        = head.cmd;
      cur_cmd_next = head.cmd;
      phase_next   = 5'd0;
      tri_cnt_next = 2'd0;
      bit_cnt_next = 4'd0;
      if (head.cmd == i2cms_pkg::CMD_WRITE) shift_byte_next = head.write_data;
      if (head.cmd == i2cms_pkg::CMD_READ) begin
        shift_byte_next = 8'd0;
        held_ack_next   = head.ack_to_send;
      end
    end

    unique case (cmd_c)
      i2cms_pkg::CMD_IDLE: begin
      end
      i2cms_pkg::CMD_START: begin
        if (phase_next == 5'd0) begin
          scl_next = 1'b1;
          sda_next = 1'b1;
        end else if (phase_next == 5'd1) sda_next = 1'b0;
        else scl_next = 1'b0;
      end
      i2cms_pkg::CMD_WRITE: begin
        len = i2cms_pkg::WRITE_LEN;
        if (bit_cnt_next < i2cms_pkg::BITS_PER_BYTE) begin
          case (tri_cnt_next)
            2'd0:    sda_next = shift_byte_next[~bit_cnt_next[2:0]];
            2'd1:    scl_next = 1'b1;
            default: scl_next = 1'b0;
          endcase
        end else begin
          case (tri_cnt_next)
            2'd0: sda_next = 1'b1;
            2'd1: begin
              scl_next            = 1'b1;
              sample_pending_next = 1'b1;
            end
            default: scl_next = 1'b0;
          endcase
        end
      end
      i2cms_pkg::CMD_READ: begin
        len = i2cms_pkg::READ_LEN;
        if (phase_next == 5'd0) sda_next = 1'b1;
        else if (phase_next <= i2cms_pkg::READ_BIT_END) begin
          if (phase_next[0]) begin
            scl_next            = 1'b1;
            sample_pending_next = 1'b1;
          end else scl_next = 1'b0;
        end else if (phase_next == i2cms_pkg::READ_ACK_SDA) sda_next = held_ack_next;
        else if (phase_next == i2cms_pkg::READ_ACK_SCL) scl_next = 1'b1;
        else scl_next = 1'b0;
      end
      i2cms_pkg::CMD_STOP: begin
        if (phase_next == 5'd0) sda_next = 1'b0;
        else if (phase_next == 5'd1) scl_next = 1'b1;
        else sda_next = 1'b1;
      end
    endcase

    if (cmd_c != i2cms_pkg::CMD_IDLE) begin
      busy = 1'b1;
      if (phase_next + 5'd1 >= len) begin
        done = 1'b1;
        if (cmd_c == i2cms_pkg::CMD_READ) read_result_next = shift_byte_next;
        cur_cmd_next = i2cms_pkg::CMD_IDLE;
        phase_next   = 5'd0;
      end else begin
        phase_next = phase_next + 5'd1;
        if (tri_cnt_next == 2'd2) begin
          tri_cnt_next = 2'd0;
          bit_cnt_next = bit_cnt_next + 4'd1;
        end else begin
          tri_cnt_next = tri_cnt_next + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_cmd        <= i2cms_pkg::CMD_IDLE;
      phase          <= 5'd0;
      tri_cnt        <= 2'd0;
      bit_cnt        <= 4'd0;
      shift_byte     <= 8'd0;
      held_ack       <= 1'b1;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
      ack_seen       <= 1'b1;
      sample_pending <= 1'b0;
      read_result    <= 8'd0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        cur_cmd        <= cur_cmd_next;
        phase          <= phase_next;
        tri_cnt        <= tri_cnt_next;
        bit_cnt        <= bit_cnt_next;
        shift_byte     <= shift_byte_next;
        held_ack       <= held_ack_next;
        scl_reg        <= scl_next;
        sda_reg        <= sda_next;
        ack_seen       <= ack_seen_next;
        sample_pending <= sample_pending_next;
        read_result    <= read_result_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      scl_level <= scl_next;
      sda_level <= sda_next;
      busy_res  <= busy;
      done_res  <= done;
      read_byte <= read_result_next;
      slave_ack <= ack_seen_next;
    end
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> busy_res)
    else $error("done without busy");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase < i2cms_pkg::WRITE_LEN)
    else $error("phase out of range");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped item gave no result");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (cur_cmd == i2cms_pkg::CMD_IDLE) |-> (phase == 5'd0 && !sample_pending))
    else $error("idle with live phase");

endmodule

// ===== hdl/i2c_master_bit_sequencer_core.sv =====
// Top level of the I2C master bit sequencer.
// Depends on i2cms_pkg, i2cms_front, i2cms_queue and i2cms_back.
//
// Input channel (in_valid/in_stall): one item per bus tick, carrying
// action, write_data, ack_to_send and the sda_line level seen during the
// previous tick. Output channel (out_valid/out_stall): one item per input
// item with the SCL/SDA levels of that tick, busy/done flags, the last
// read byte and the last slave acknowledge.
// Throughput is one item per cycle while out_stall is low.
// The accept edge writes the item into the two-entry queue; while the
// output register is free or being taken, the queue head moves through
// the back tick logic into the output register (only out_valid is reset).
// When the receiver stalls, the result register holds and the queue
// fills; in_stall rises once both queue entries are taken.
// Reset brings the internal state to idle with both pins released, the
// slave acknowledge at one, the read byte at zero and no item in flight.
module i2c_master_bit_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] action,
  input  logic [7:0] write_data,
  input  logic       ack_to_send,
  input  logic       sda_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_byte,
  output logic       slave_ack
);

  i2cms_pkg::q_stat_t q_stat;
  i2cms_pkg::item_t   push_item;
  i2cms_pkg::item_t   head;
  logic               push;
  logic               pop;

  i2cms_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .write_data  (write_data),
    .ack_to_send (ack_to_send),
    .sda_line    (sda_line),
    .q_stat      (q_stat),
    .push        (push),
    .push_item   (push_item)
  );

  i2cms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  i2cms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .scl_level (scl_level),
    .sda_level (sda_level),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .read_byte (read_byte),
    .slave_ack (slave_ack)
  );

endmodule
